>>> rtl/etc_pkg.sv
// Package: shared types and constants of the extended timebase clock.
package etc_pkg;

    localparam int unsigned RAW_W    = 32;
    localparam int unsigned TICK_W   = 64;
    localparam int unsigned PERIOD_W = 8;

    localparam logic [PERIOD_W-1:0] RESET_TICK_PERIOD = 8'd5;

    typedef enum logic [2:0] {
        ACT_SAMPLE   = 3'd0,
        ACT_SET_TIME = 3'd1,
        ACT_ADJUST   = 3'd2,
        ACT_CAPTURE  = 3'd3,
        ACT_CONVERT  = 3'd4,
        ACT_ORIGIN   = 3'd5
    } action_t;

    typedef struct packed {
        action_t                   action;
        logic [RAW_W-1:0]          raw_count;
        logic [RAW_W-1:0]          capture_count;
        logic signed [TICK_W-1:0]  set_time_ns;
        logic signed [TICK_W-1:0]  adjust_ns;
        logic [TICK_W-1:0]         tick_value;
    } item_t;

    typedef struct packed {
        logic [TICK_W-1:0] tick_count;
        logic [TICK_W-1:0] time_ns;
    } result_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] tick_period_ns;
    } cfg_t;

    // Controls from the handshake logic to the timebase state.
    typedef struct packed {
        logic load;
        logic rescale;
    } ctrl_t;

endpackage

>>> rtl/etc_chan_if.sv
// Interface: one valid/ready channel carrying a typed payload.
interface etc_chan_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

>>> rtl/extended_timebase_clock.sv
// Top level: extended timebase clock with request, result and period channels.
// Latency: a result is registered at the edge that accepts its request and is
//   offered on the next cycle.
// Throughput: one request per cycle while results are drained; after a period
//   write, requests wait while the 64x8 multiplier rebuilds the scaled ticks.
// Reset: ticks, phase base and last count clear to zero, period returns to 5.
module extended_timebase_clock (
    input  logic        clk,
    input  logic        rst_n,
    etc_chan_if.sink    item,
    etc_chan_if.source  result,
    etc_chan_if.sink    cfg
);
    import etc_pkg::*;

    logic [PERIOD_W-1:0] period_reg;
    logic                rescale_reg;
    logic                out_valid_reg;
    result_t             out_reg;
    result_t             calc;
    ctrl_t               ctrl;
    logic                take;

    // Accept while no rescale is pending and the output slot is free or being drained.
    assign item.ready   = !rescale_reg && (!out_valid_reg || result.ready);
    assign take         = item.valid && item.ready;
    assign cfg.ready    = 1'b1;
    assign ctrl.load    = take;
    assign ctrl.rescale = rescale_reg;

    etc_timebase u_timebase (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .item   (item.payload),
        .period (period_reg),
        .result (calc)
    );

    // Hold the period and flag a rescale after each write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= RESET_TICK_PERIOD;
            rescale_reg <= 1'b0;
        end
        else
        begin
            rescale_reg <= cfg.valid;
            if (cfg.valid)
            begin
                period_reg <= cfg.payload.tick_period_ns;
            end
        end
    end

    // Output register: load on accept, drop when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= calc;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

endmodule

>>> rtl/etc_timebase.sv
// Module: timebase state and per-request tick and time arithmetic.
module etc_timebase (
    input  logic                          clk,
    input  logic                          rst_n,
    input  etc_pkg::ctrl_t                ctrl,
    input  etc_pkg::item_t                item,
    input  logic [etc_pkg::PERIOD_W-1:0]  period,
    output etc_pkg::result_t              result
);
    import etc_pkg::*;

    // Timebase state; scaled_reg tracks ticks_reg * period modulo 2^64.
    logic [TICK_W-1:0] ticks_reg, ticks_next;
    logic [TICK_W-1:0] scaled_reg, scaled_next;
    logic [TICK_W-1:0] base_reg, base_next;
    logic [RAW_W-1:0]  last_reg, last_next;

    logic [RAW_W-1:0]         delta;
    logic signed [RAW_W+8:0]  delta_prod;
    logic [TICK_W-1:0]        delta_ext;
    logic [TICK_W-1:0]        delta_scaled;
    logic [TICK_W-1:0]        ticks_adv;
    logic [TICK_W-1:0]        scaled_adv;
    logic [TICK_W-1:0]        conv_scaled;
    logic [TICK_W-1:0]        rescaled;
    logic [TICK_W-1:0]        base_adj;

    // Signed 32-bit step from the last sample, for the counter or a capture.
    always_comb
    begin
        if (item.action == ACT_CAPTURE)
        begin
            delta = item.capture_count - last_reg;
        end
        else
        begin
            delta = item.raw_count - last_reg;
        end
    end

    assign delta_prod   = $signed(delta) * $signed({1'b0, period});
    assign delta_ext    = {{(TICK_W-RAW_W){delta[RAW_W-1]}}, delta};
    assign delta_scaled = {{(TICK_W-RAW_W-9){delta_prod[RAW_W+8]}}, delta_prod};
    assign ticks_adv    = ticks_reg + delta_ext;
    assign scaled_adv   = scaled_reg + delta_scaled;
    assign conv_scaled  = item.tick_value * {{(TICK_W-PERIOD_W){1'b0}}, period};
    assign rescaled     = ticks_reg * {{(TICK_W-PERIOD_W){1'b0}}, period};
    assign base_adj     = base_reg + item.adjust_ns;

    // Decode the action into next state and the result.
    always_comb
    begin
        ticks_next        = ticks_reg;
        scaled_next       = scaled_reg;
        base_next         = base_reg;
        last_next         = last_reg;
        result.tick_count = ticks_reg;
        result.time_ns    = scaled_reg + base_reg;
        case (item.action)
            ACT_SAMPLE:
            begin
                ticks_next        = ticks_adv;
                scaled_next       = scaled_adv;
                last_next         = item.raw_count;
                result.tick_count = ticks_adv;
                result.time_ns    = scaled_adv + base_reg;
            end
            ACT_SET_TIME:
            begin
                ticks_next        = ticks_adv;
                scaled_next       = scaled_adv;
                last_next         = item.raw_count;
                base_next         = item.set_time_ns - scaled_adv;
                result.tick_count = ticks_adv;
                result.time_ns    = item.set_time_ns;
            end
            ACT_ADJUST:
            begin
                base_next      = base_adj;
                result.time_ns = scaled_reg + base_adj;
            end
            ACT_CAPTURE:
            begin
                result.tick_count = ticks_adv;
                result.time_ns    = scaled_adv + base_reg;
            end
            ACT_CONVERT:
            begin
                result.tick_count = item.tick_value;
                result.time_ns    = conv_scaled + base_reg;
            end
            ACT_ORIGIN:
            begin
                last_next = item.raw_count;
            end
            default:
            begin
                ticks_next = ticks_reg;
            end
        endcase
    end

    // Advance state on an accepted request; rebuild the scaled ticks after a period change.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg  <= '0;
            scaled_reg <= '0;
            base_reg   <= '0;
            last_reg   <= '0;
        end
        else if (ctrl.rescale)
        begin
            scaled_reg <= rescaled;
        end
        else if (ctrl.load)
        begin
            ticks_reg  <= ticks_next;
            scaled_reg <= scaled_next;
            base_reg   <= base_next;
            last_reg   <= last_next;
        end
    end

endmodule
